// ----- rtl/sm4_pkg.sv -----
// ----------------------------------------------------------------------------
// SM4 cipher package
// Shared types, operation codes and the S-box table for the SM4 core.
// ----------------------------------------------------------------------------
package sm4_pkg;

  // Number of round-key slots held by default.
  localparam int KEY_WORDS_DEFAULT = 32;

  // Round count and the width of the round counter.
  localparam int ROUND_COUNT = 32;
  localparam int ROUND_W     = $clog2(ROUND_COUNT);

  // Operation codes carried in the opcode field.
  localparam logic [1:0] OP_LOAD_KEY = 2'd0;
  localparam logic [1:0] OP_ENCRYPT  = 2'd1;
  localparam logic [1:0] OP_DECRYPT  = 2'd2;

  // One request beat.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [4:0]  key_index;
    logic [31:0] key_word;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } sm4_req_t;

  // One response beat.
  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } sm4_rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic               key_we;
    logic [ROUND_W-1:0] key_raddr;
    logic               load_block;
    logic               round_en;
    logic               load_out;
  } sm4_cmd_t;

  // SM4 S-box.
  localparam logic [7:0] SBOX [0:255] = '{
    8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
    8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
    8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
    8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
    8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
    8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
    8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
    8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
    8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
    8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
    8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
    8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
    8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
    8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
    8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
    8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
    8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
    8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
    8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
    8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
    8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
    8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
    8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
    8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
    8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
    8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
    8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
    8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
    8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
    8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
    8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
    8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
  };

endpackage

// ----- rtl/sm4_ram.sv -----
// ----------------------------------------------------------------------------
// SM4 generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module sm4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/sm4_dp.sv -----
// ----------------------------------------------------------------------------
// SM4 datapath
// Round-key store, four-word block state with one round unit, and the
// response register.
// ----------------------------------------------------------------------------
module sm4_dp #(
  parameter int KEY_WORDS = sm4_pkg::KEY_WORDS_DEFAULT
) (
  input  logic             clk,
  input  sm4_pkg::sm4_cmd_t cmd,
  input  sm4_pkg::sm4_req_t req,
  output sm4_pkg::sm4_rsp_t rsp
);
  import sm4_pkg::*;

  localparam int AW = $clog2(KEY_WORDS);

  logic [31:0] x0, x1, x2, x3;
  logic [31:0] round_key;
  logic [31:0] t_in;
  logic [31:0] sub;
  logic [31:0] lin;
  logic [31:0] new_word;
  logic        key_wr;

  // Key writes beyond the table are dropped.
  assign key_wr = cmd.key_we && (32'(req.key_index) < KEY_WORDS);

  sm4_ram #(
    .WIDTH (32),
    .DEPTH (KEY_WORDS)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_wr),
    .waddr (AW'(req.key_index)),
    .wdata (req.key_word),
    .raddr (AW'(cmd.key_raddr)),
    .rdata (round_key)
  );

  // One round: byte substitution followed by the linear mix.
  always_comb begin
    t_in     = x1 ^ x2 ^ x3 ^ round_key;
    sub      = {SBOX[t_in[31:24]], SBOX[t_in[23:16]], SBOX[t_in[15:8]], SBOX[t_in[7:0]]};
    lin      = sub ^ {sub[29:0], sub[31:30]} ^ {sub[21:0], sub[31:22]}
             ^ {sub[13:0], sub[31:14]} ^ {sub[7:0], sub[31:8]};
    new_word = x0 ^ lin;
  end

  // Block state: loaded from the request, then shifted once per round.
  always_ff @(posedge clk) begin
    if (cmd.load_block) begin
      x0 <= req.block_high[63:32];
      x1 <= req.block_high[31:0];
      x2 <= req.block_low[63:32];
      x3 <= req.block_low[31:0];
    end else if (cmd.round_en) begin
      x0 <= x1;
      x1 <= x2;
      x2 <= x3;
      x3 <= new_word;
    end
  end

  // Response register holds the last four words in reverse order.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp.result_high <= {x3, x2};
      rsp.result_low  <= {x1, x0};
    end
  end

endmodule

// ----- rtl/sm4_ctrl.sv -----
// ----------------------------------------------------------------------------
// SM4 controller
// Sequences key loads and the 32 rounds of one block, and owns the
// request and response handshakes.
// ----------------------------------------------------------------------------
module sm4_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic [1:0]        req_opcode,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output sm4_pkg::sm4_cmd_t cmd
);
  import sm4_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PREP = 4'b0010,
    S_RUN  = 4'b0100,
    S_WB   = 4'b1000
  } state_t;

  state_t             state, state_next;
  logic [ROUND_W-1:0] cnt, cnt_next;
  logic               decrypt, decrypt_next;
  logic               accept;
  logic               rsp_free;
  logic [ROUND_W-1:0] key_round;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign rsp_free  = !rsp_valid || rsp_ready;

  // Round whose key is fetched for the following cycle.
  always_comb begin
    if (state == S_RUN) begin
      key_round = cnt + ROUND_W'(1);
    end else begin
      key_round = '0;
    end
  end

  // Next-state and command logic.
  always_comb begin
    // Decryption walks the key table backwards.
    cmd.key_raddr  = decrypt ? ~key_round : key_round;
    state_next     = state;
    cnt_next       = cnt;
    decrypt_next   = decrypt;
    cmd.key_we     = 1'b0;
    cmd.load_block = 1'b0;
    cmd.round_en   = 1'b0;
    cmd.load_out   = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (req_opcode == OP_LOAD_KEY) begin
            cmd.key_we = 1'b1;
          end else if (req_opcode == OP_ENCRYPT || req_opcode == OP_DECRYPT) begin
            cmd.load_block = 1'b1;
            decrypt_next   = (req_opcode == OP_DECRYPT);
            state_next     = S_PREP;
          end
        end
      end
      S_PREP: begin
        state_next = S_RUN;
      end
      S_RUN: begin
        cmd.round_en = 1'b1;
        cnt_next     = cnt + ROUND_W'(1);
        if (cnt == ROUND_W'(ROUND_COUNT - 1)) begin
          state_next = S_WB;
        end
      end
      S_WB: begin
        if (rsp_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      decrypt   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      decrypt <= decrypt_next;
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // A waiting response is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!rsp_valid || rsp_ready))
    else $error("response register overwritten");

  // The last round always leads to write-back.
  a_last_round: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && cnt == ROUND_W'(ROUND_COUNT - 1)) |=> (state == S_WB))
    else $error("round sequence did not end in write-back");

  // The round counter rests at zero outside the round loop.
  a_cnt_rest: assert property (@(posedge clk) disable iff (rst)
    (state != S_RUN) |-> (cnt == '0))
    else $error("round counter not at zero outside rounds");

  // Key writes happen only on an accepted beat.
  a_key_write: assert property (@(posedge clk) disable iff (rst)
    cmd.key_we |-> accept)
    else $error("key write without an accepted beat");

  // An accepted block starts the key prefetch in the next cycle.
  a_block_start: assert property (@(posedge clk) disable iff (rst)
    cmd.load_block |=> (state == S_PREP))
    else $error("block accepted without starting rounds");
`endif

endmodule

// ----- rtl/sm4_block_cipher_top.sv -----
// ----------------------------------------------------------------------------
// SM4 block cipher top level
// Loads round-key words and encrypts or decrypts 128-bit blocks.
//
//   Channel  Dir  Handshake              Payload
//   req      in   req_valid / req_ready  sm4_req_t (opcode, key, block)
//   rsp      out  rsp_valid / rsp_ready  sm4_rsp_t (result block)
//
// A key-load beat is written straight into the key table. A block passes
// from acceptance to the response register through one key prefetch from
// the key RAM, 32 rounds through the single round unit, and write-back.
// Reset is synchronous and clears control only; the key table holds no
// value until written. A stalled response holds the core in write-back
// until the response register is free; a new request is taken meanwhile
// only once the core has returned to idle.
// ----------------------------------------------------------------------------
module sm4_block_cipher_top #(
  parameter int KEY_WORDS = sm4_pkg::KEY_WORDS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  sm4_pkg::sm4_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output sm4_pkg::sm4_rsp_t rsp
);
  import sm4_pkg::*;

  sm4_cmd_t cmd;

  // Sequencer.
  sm4_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_opcode (req.opcode),
    .req_ready  (req_ready),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .cmd        (cmd)
  );

  // Key store, round unit and response register.
  sm4_dp #(
    .KEY_WORDS (KEY_WORDS)
  ) u_dp (
    .clk (clk),
    .cmd (cmd),
    .req (req),
    .rsp (rsp)
  );

endmodule
